// File: rtl/core/count_smaller_after_self_assert.svh
// Assertion macros used by the checker of the count-smaller block.
`ifndef COUNT_SMALLER_AFTER_SELF_ASSERT_SVH
`define COUNT_SMALLER_AFTER_SELF_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/csa_pkg.sv
// Package with sizes and shared types of the count-smaller block.
`timescale 1ns / 1ps
package csa_pkg;
    localparam int MAX_ITEMS   = 64;
    localparam int VALUE_BITS  = 16;
    localparam int CNT_W       = 6;
    localparam int POS_W       = 6;
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int FILL_W      = $clog2(MAX_ITEMS + 1);
    localparam int IN_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((POS_W + CNT_W + 7) / 8) * 8;

    // Controls broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic                         accept;
        logic                         shift;
        logic signed [VALUE_BITS-1:0] value;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_LOAD  = 2'b01,
        S_DRAIN = 2'b10
    } t_state;
endpackage

// File: rtl/core/count_smaller_after_self.sv
// An accepted beat is presented to every cell of the chain at once.
// After the beat with tlast the first result is shown in the next cycle.
// Results then leave one per cycle while i_m_tready is high, shifted out of cell 0 of the chain.
// No input is taken while results are being output.
// Reset clears the fill count, the state and the overflow flag; there is no clearing pass.
`timescale 1ns / 1ps
module count_smaller_after_self import csa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [15:0] value
    input  logic                   i_s_tlast,   // is_last
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [5:0] position, [11:6] smaller_after
    output logic                   o_m_tlast,   // last_of_run
    output logic                   o_m_tuser    // overflow
);
    t_state              r_state;
    t_state              n_state;
    logic [FILL_W-1:0]   r_fill;
    logic [FILL_W-1:0]   n_fill;
    logic [IDX_W-1:0]    r_pos;
    logic [IDX_W-1:0]    n_pos;
    logic                r_dropped;
    logic                n_dropped;
    logic                in_fire;
    logic                out_fire;
    logic                full;
    t_cell_ctl           ctl;
    logic [MAX_ITEMS-1:0] load_vec;

    logic signed [VALUE_BITS-1:0] c_value [MAX_ITEMS];
    logic        [CNT_W-1:0]      c_count [MAX_ITEMS];

    assign o_s_tready = (r_state == S_LOAD);
    assign o_m_tvalid = (r_state == S_DRAIN);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign out_fire   = o_m_tvalid && i_m_tready;
    assign full       = (r_fill == FILL_W'(MAX_ITEMS));

    assign ctl.accept = in_fire && !full;
    assign ctl.shift  = out_fire;
    assign ctl.value  = i_s_tdata[VALUE_BITS-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            assign load_vec[gi] = ctl.accept && (r_fill == FILL_W'(gi));
            if (gi == MAX_ITEMS - 1) begin : g_tail
                csa_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctl        (ctl),
                    .i_load       (load_vec[gi]),
                    .i_next_value ('0),
                    .i_next_count ('0),
                    .o_value      (c_value[gi]),
                    .o_count      (c_count[gi])
                );
            end else begin : g_body
                csa_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctl        (ctl),
                    .i_load       (load_vec[gi]),
                    .i_next_value (c_value[gi+1]),
                    .i_next_count (c_count[gi+1]),
                    .o_value      (c_value[gi]),
                    .o_count      (c_count[gi])
                );
            end
        end
    endgenerate

    // During output the fill count doubles as the number of results still to go.
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_pos     = r_pos;
        n_dropped = r_dropped;
        unique case (r_state)
            S_LOAD: begin
                if (in_fire) begin
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                    if (i_s_tlast) begin
                        n_state = S_DRAIN;
                        n_pos   = '0;
                    end
                end
            end
            S_DRAIN: begin
                if (out_fire) begin
                    n_fill = r_fill - FILL_W'(1);
                    n_pos  = r_pos + IDX_W'(1);
                    if (r_fill == FILL_W'(1)) begin
                        n_state   = S_LOAD;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_fill    <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_dropped <= n_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
    end

    assign o_m_tdata = OUT_TDATA_W'({c_count[0], POS_W'(r_pos)});
    assign o_m_tlast = (r_fill == FILL_W'(1));
    assign o_m_tuser = r_dropped;
endmodule

// File: rtl/core/csa_cell.sv
// One cell of the chain: a stored value and its running count.
`timescale 1ns / 1ps
module csa_cell import csa_pkg::*; (
    input  logic                         i_clk,
    input  t_cell_ctl                    i_ctl,
    input  logic                         i_load,
    input  logic signed [VALUE_BITS-1:0] i_next_value,
    input  logic        [CNT_W-1:0]      i_next_count,
    output logic signed [VALUE_BITS-1:0] o_value,
    output logic        [CNT_W-1:0]      o_count
);
    logic signed [VALUE_BITS-1:0] r_value;
    logic signed [VALUE_BITS-1:0] n_value;
    logic        [CNT_W-1:0]      r_count;
    logic        [CNT_W-1:0]      n_count;
    logic                         greater;

    assign greater = (r_value > i_ctl.value) && (r_count != {CNT_W{1'b1}});

    always_comb begin
        n_value = r_value;
        n_count = r_count;
        priority if (i_load) begin
            n_value = i_ctl.value;
            n_count = '0;
        end else if (i_ctl.shift) begin
            n_value = i_next_value;
            n_count = i_next_count;
        end else if (i_ctl.accept && greater) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_count <= n_count;
    end

    assign o_value = r_value;
    assign o_count = r_count;
endmodule

// File: rtl/core/csa_checker.sv
// Port-level checker for the count-smaller block, bound to the top level.
`timescale 1ns / 1ps
`include "count_smaller_after_self_assert.svh"
module csa_checker import csa_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tlast,
    input  logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                   o_m_tlast,
    input  logic                   o_m_tuser
);
    logic in_fire;
    logic out_fire;

    assign in_fire  = i_s_tvalid && o_s_tready;
    assign out_fire = o_m_tvalid && i_m_tready;

    // While results are pending no new beat may enter.
    `CSA_ASSERT_SAME(a_no_input_in_drain, o_m_tvalid, !o_s_tready, "input taken during output")
    `CSA_ASSERT_NEXT(a_last_starts_drain, in_fire && i_s_tlast, o_m_tvalid, "no result after tlast")
    `CSA_ASSERT_NEXT(a_drain_ends, out_fire && o_m_tlast, !o_m_tvalid && o_s_tready, "run did not end")
    `CSA_ASSERT_NEXT(a_hold_stalled, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")
endmodule

bind count_smaller_after_self csa_checker u_csa_checker (.*);
